### hdl/plu_pkg.sv
// Shared types, constants and constant-table functions for the permutation unranker.
`default_nettype none

package plu_pkg;

  localparam int RANK_W = 29;
  localparam int NUSE_W = 4;
  localparam int POS_W  = 4;
  localparam int ELEM_W = 4;

  localparam int MAX_ELEMENTS_DEF = 12;
  localparam logic [NUSE_W-1:0] N_IN_USE_RESET = NUSE_W'(12);

  // Default widths of the divider, matching the default element count.
  localparam int QUOT_W_DEF = $clog2(MAX_ELEMENTS_DEF);
  localparam int DIV_W_DEF  = RANK_W + QUOT_W_DEF;
  localparam int CNT_W      = $clog2(RANK_W + 1);

  localparam logic [63:0] RANK_MAX = (64'd1 << RANK_W) - 64'd1;

  typedef struct packed {
    logic load;   // take a new dividend into the remainder register
    logic start;  // begin a division with a fresh divisor
  } div_cmd_t;

  function automatic logic [63:0] fact(input int n);
    logic [63:0] f;
    f = 64'd1;
    for (int i = 2; i <= n; i++) begin
      f = f * 64'(i);
    end
    return f;
  endfunction

  // Quotient bits needed to reduce any rank modulo n!.
  function automatic int red_bits(input int n);
    logic [63:0] f;
    int bits;
    f = fact(n);
    bits = 0;
    if (f <= RANK_MAX) begin
      for (int k = 0; k < RANK_W; k++) begin
        if ((f << k) <= RANK_MAX) bits = k + 1;
      end
    end
    return bits;
  endfunction

  function automatic logic [63:0] red_dvs(input int n);
    int bits;
    bits = red_bits(n);
    if (bits == 0) return 64'd0;
    return fact(n) << (bits - 1);
  endfunction

  // Bits of the digit for step j, which never exceeds j.
  function automatic int dig_bits(input int j);
    int bits;
    bits = 0;
    for (int b = 0; b < 8; b++) begin
      if (64'(j + 1) > (64'd1 << b)) bits = b + 1;
    end
    return bits;
  endfunction

  // Factorials beyond the rank range saturate; the digit there is always zero.
  function automatic logic [63:0] dig_dvs(input int j);
    logic [63:0] f;
    int bits;
    f = fact(j);
    bits = dig_bits(j);
    if (f > (64'd1 << RANK_W)) f = 64'd1 << RANK_W;
    if (bits == 0) return 64'd0;
    return f << (bits - 1);
  endfunction

endpackage

`default_nettype wire

### hdl/plu_div.sv
// Shared restoring divider: one compare and subtract per cycle against a shifting divisor.
`default_nettype none

module plu_div #(
  parameter int DW = plu_pkg::DIV_W_DEF,
  parameter int QW = plu_pkg::QUOT_W_DEF,
  parameter int CW = plu_pkg::CNT_W
) (
  input  logic                      clk,
  input  logic                      rst,
  input  plu_pkg::div_cmd_t         cmd,
  input  logic [plu_pkg::RANK_W-1:0] load_val,
  input  logic [DW-1:0]             dvs_init,
  input  logic [CW-1:0]             nbits,
  output logic                      done,
  output logic [QW-1:0]             quot
);

  logic                       busy;
  logic [CW-1:0]              cnt;
  logic [DW-1:0]              dvs;
  logic [plu_pkg::RANK_W-1:0] rem;
  logic [DW-1:0]              rem_ext;
  logic                       ge;

  assign rem_ext = DW'(rem);
  assign ge      = rem_ext >= dvs;
  assign done    = busy && (cnt == CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.start) begin
      busy <= (nbits != '0);
      cnt  <= nbits;
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvs  <= dvs_init;
      quot <= '0;
    end else if (busy) begin
      quot <= QW'({quot, ge});
      dvs  <= dvs >> 1;
    end
    if (cmd.load) begin
      rem <= load_val;
    end else if (busy && !cmd.start && ge) begin
      rem <= plu_pkg::RANK_W'(rem_ext - dvs);
    end
  end

endmodule

`default_nettype wire

### hdl/permutation_lex_unrank.sv
// Top level of the lexicographic permutation unranker.
//
//   channel | signals                              | direction | item
//   --------+--------------------------------------+-----------+---------------------------
//   cfg     | cfg_valid, cfg_ready, cfg_data       | in        | new n_in_use value
//   in      | in_valid, in_ready, rank             | in        | one rank to unrank
//   out     | out_valid, out_ready, position,      | out       | one permutation element,
//           | element, last                        |           | n of them per input item
//
// An item reduces the rank modulo n!, then finds a digit of ceil(log2(j+1)) bits for each
// step j = n-1 down to 1, places the n-1 digits and emits n elements. The reduction takes
// R(n) quotient bits of rank / n! (zero when n! exceeds the rank range, one for n = 12). The
// single compare and subtract unit in plu_div sets the digit time.
// Reset is synchronous and restores n_in_use to 12. in_ready is high only when idle;
// a stalled result holds its fields until out_ready rises. cfg_ready is always high.
`default_nettype none

module permutation_lex_unrank #(
  parameter int MAX_ELEMENTS = plu_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [plu_pkg::NUSE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [plu_pkg::RANK_W-1:0] rank,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [plu_pkg::POS_W-1:0]  position,
  output logic [plu_pkg::ELEM_W-1:0] element,
  output logic                       last
);

  localparam int NW = $clog2(MAX_ELEMENTS + 1);
  localparam int QW = $clog2(MAX_ELEMENTS);
  localparam int DW = plu_pkg::RANK_W + QW;
  localparam int CW = plu_pkg::CNT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_REDUCE = 6'b000010,
    S_SETUP  = 6'b000100,
    S_DIGIT  = 6'b001000,
    S_PLACE  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [plu_pkg::NUSE_W-1:0] n_in_use;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_cur;
  logic [NW-1:0] jc;
  logic [NW-1:0] pc;
  logic [NW-1:0] pos;
  logic          dig_pend;
  logic [QW-1:0] dig  [0:MAX_ELEMENTS-1];
  logic [NW-1:0] pbuf [0:MAX_ELEMENTS-1];

  logic [DW-1:0] red_dvs_tab  [0:MAX_ELEMENTS];
  logic [CW-1:0] red_bits_tab [0:MAX_ELEMENTS];
  logic [DW-1:0] dig_dvs_tab  [0:MAX_ELEMENTS];
  logic [CW-1:0] dig_bits_tab [0:MAX_ELEMENTS];

  plu_pkg::div_cmd_t           cmd;
  logic [DW-1:0]               dvs_init;
  logic [CW-1:0]               nbits;
  logic                        div_done;
  logic [QW-1:0]               quot;
  logic [QW-1:0]               d;

  for (genvar g = 0; g <= MAX_ELEMENTS; g++) begin : g_tab
    assign red_dvs_tab[g]  = DW'(plu_pkg::red_dvs(g));
    assign red_bits_tab[g] = CW'(plu_pkg::red_bits(g));
    assign dig_dvs_tab[g]  = DW'(plu_pkg::dig_dvs(g));
    assign dig_bits_tab[g] = CW'(plu_pkg::dig_bits(g));
  end

  plu_div #(
    .DW (DW),
    .QW (QW),
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .load_val (rank),
    .dvs_init (dvs_init),
    .nbits    (nbits),
    .done     (div_done),
    .quot     (quot)
  );

  // A zero count behaves as one element; counts above the maximum saturate.
  always_comb begin
    if (n_in_use == '0) begin
      n_eff = NW'(1);
    end else if (32'(n_in_use) > MAX_ELEMENTS) begin
      n_eff = NW'(MAX_ELEMENTS);
    end else begin
      n_eff = NW'(n_in_use);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign position  = plu_pkg::POS_W'(pos);
  assign element   = plu_pkg::ELEM_W'(pbuf[0]);
  assign last      = (pos == n_cur - NW'(1));
  assign d         = dig[0];

  always_comb begin
    state_next = state;
    cmd        = '0;
    dvs_init   = dig_dvs_tab[jc];
    nbits      = dig_bits_tab[jc];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (red_bits_tab[n_eff] != '0) begin
            cmd.start  = 1'b1;
            dvs_init   = red_dvs_tab[n_eff];
            nbits      = red_bits_tab[n_eff];
            state_next = S_REDUCE;
          end else begin
            state_next = S_SETUP;
          end
        end
      end
      S_REDUCE: begin
        if (div_done) state_next = S_SETUP;
      end
      S_SETUP: begin
        if (jc == '0) begin
          state_next = (n_cur == NW'(1)) ? S_EMIT : S_PLACE;
        end else begin
          cmd.start  = 1'b1;
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (div_done) state_next = S_SETUP;
      end
      S_PLACE: begin
        if (pc == NW'(1)) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_ready && last) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      n_in_use <= plu_pkg::N_IN_USE_RESET;
      dig_pend <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) n_in_use <= cfg_data;
      if (state == S_DIGIT && div_done) begin
        dig_pend <= 1'b1;
      end else if (state == S_SETUP) begin
        dig_pend <= 1'b0;
      end
    end
  end

  // Digits are pushed from the most significant step down and popped in the
  // opposite order; the permutation builds by shifting new elements in at the front.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          n_cur   <= n_eff;
          jc      <= n_eff - NW'(1);
          pbuf[0] <= NW'(1);
        end
      end
      S_SETUP: begin
        if (dig_pend) begin
          dig[0] <= quot;
          for (int i = 1; i < MAX_ELEMENTS; i++) begin
            dig[i] <= dig[i-1];
          end
        end
        if (jc == '0) begin
          pc  <= n_cur - NW'(1);
          pos <= '0;
        end else begin
          jc <= jc - NW'(1);
        end
      end
      S_PLACE: begin
        pbuf[0] <= NW'(d) + NW'(1);
        for (int i = 1; i < MAX_ELEMENTS; i++) begin
          pbuf[i] <= (pbuf[i-1] > NW'(d)) ? pbuf[i-1] + NW'(1) : pbuf[i-1];
        end
        for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
          dig[i] <= dig[i+1];
        end
        pc <= pc - NW'(1);
      end
      S_EMIT: begin
        if (out_ready) begin
          for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
            pbuf[i] <= pbuf[i+1];
          end
          pos <= pos + NW'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/plu_checker.sv
// Port-level checks for the permutation unranker, bound to its top level.
`default_nettype none

module plu_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [plu_pkg::POS_W-1:0]  position,
  input logic [plu_pkg::ELEM_W-1:0] element,
  input logic                       last
);

  // A stalled result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable({position, element, last}))
    else $error("result changed while stalled");

  // The block never takes an item while results are still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input ready while results pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting an item");

  // Positions count up by one within a permutation.
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=>
      out_valid && (position == plu_pkg::POS_W'($past(position) + plu_pkg::POS_W'(1))))
    else $error("position did not advance by one");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last |=> in_ready && !out_valid)
    else $error("not idle after the final element");

endmodule

bind permutation_lex_unrank plu_checker u_plu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .position  (position),
  .element   (element),
  .last      (last)
);

`default_nettype wire

### sim/permutation_lex_unrank_tb.sv
// Self-checking testbench for the lexicographic permutation unranker, with a scoreboard.
`default_nettype none

module permutation_lex_unrank_tb;

  localparam int RANK_W = plu_pkg::RANK_W;
  localparam int NUSE_W = plu_pkg::NUSE_W;
  localparam int POS_W  = plu_pkg::POS_W;
  localparam int ELEM_W = plu_pkg::ELEM_W;

  localparam int MAX_COUNT   = 12;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 26;
  localparam logic [RANK_W-1:0] RANK_ALL_ONES = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [ELEM_W-1:0] element;
    logic              last;
  } perm_elem_t;

  // Number of permutations of n elements.
  function automatic longint unsigned perm_count(input int n);
    longint unsigned f;
    f = 1;
    for (int i = 2; i <= n; i++) f = f * longint'(i);
    return f;
  endfunction

  class perm_checker;
    logic [NUSE_W-1:0] count_reg;
    perm_elem_t        expected_elems[$];
    int                errors;

    function new();
      count_reg = 4'd12;
      errors    = 0;
    endfunction

    function void set_count(input logic [NUSE_W-1:0] v);
      count_reg = v;
    endfunction

    function int elem_count();
      int n;
      n = int'(count_reg);
      if (n < 1) n = 1;
      if (n > MAX_COUNT) n = MAX_COUNT;
      return n;
    endfunction

    function int pending();
      return expected_elems.size();
    endfunction

    // Builds the permutation from its factoradic digits, last position first.
    function void note_rank(input logic [RANK_W-1:0] r);
      int                n;
      longint unsigned   rem;
      longint unsigned   digit;
      logic [ELEM_W-1:0] slots[MAX_COUNT];
      perm_elem_t        e;
      n   = elem_count();
      rem = longint'(r) % perm_count(n);
      foreach (slots[k]) slots[k] = '0;
      slots[n-1] = 1;
      for (int j = 1; j < n; j++) begin
        digit = (rem % perm_count(j + 1)) / perm_count(j);
        rem   = rem - digit * perm_count(j);
        slots[n-j-1] = ELEM_W'(digit + 1);
        for (int i = n - j; i < n; i++) begin
          if (longint'(slots[i]) > digit) slots[i] = slots[i] + 1'b1;
        end
      end
      for (int i = 0; i < n; i++) begin
        e.position = POS_W'(i);
        e.element  = slots[i];
        e.last     = (i + 1 == n);
        expected_elems.insert(expected_elems.size(), e);
      end
    endfunction

    function void check_element(input logic [POS_W-1:0] p, input logic [ELEM_W-1:0] el,
                                input logic l);
      perm_elem_t want;
      if (expected_elems.size() == 0) begin
        $error("result with no item pending: position %0d element %0d last %0b", p, el, l);
        errors++;
        return;
      end
      want = expected_elems.pop_front();
      if (want.position !== p) begin
        $error("position: expected %0d, got %0d", want.position, p);
        errors++;
      end
      if (want.element !== el) begin
        $error("element: expected %0d, got %0d", want.element, el);
        errors++;
      end
      if (want.last !== l) begin
        $error("last: expected %0b, got %0b", want.last, l);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [NUSE_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [RANK_W-1:0] rank = '0;
  logic              out_valid;
  logic              out_ready;
  logic [POS_W-1:0]  position;
  logic [ELEM_W-1:0] element;
  logic              last;

  perm_checker sb;
  int          in_idle_pct   = 0;
  int          out_stall_pct = 0;
  int          hold_req      = 0;
  int          cycle_count   = 0;

  permutation_lex_unrank DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rank      (rank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .position  (position),
    .element   (element),
    .last      (last)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls, plus one long hold each time the main flow requests it.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_count(cfg_data);
      if (in_valid && in_ready) sb.note_rank(rank);
      if (out_valid && out_ready) sb.check_element(position, element, last);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        in_idle_pct = 0;
        out_stall_pct <= 0;
      end
      IDLE_SENDER: begin
        in_idle_pct = 65;
        out_stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        in_idle_pct = 0;
        out_stall_pct <= 65;
      end
      default: begin
        in_idle_pct = 12;
        out_stall_pct <= 12;
      end
    endcase
  endtask

  // Valid stays high across back-to-back items and is lowered only for a gap.
  task automatic send_rank(input logic [RANK_W-1:0] r);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    rank     <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // The scoreboard notes an item at its accepting edge, so the count is read an edge later.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [NUSE_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Mix of full-range ranks, ranks below n! and ranks just around the wrap point.
  function automatic logic [RANK_W-1:0] pick_rank(input int n);
    longint unsigned f;
    longint unsigned v;
    f = perm_count(n);
    case ($urandom_range(3))
      0: v = longint'($urandom());
      1: v = longint'($urandom_range(int'(f - 1)));
      2: v = (f > 4) ? f - 1 - longint'($urandom_range(3)) : longint'($urandom());
      default: v = f + longint'($urandom_range(3));
    endcase
    return RANK_W'(v);
  endfunction

  initial begin
    logic [NUSE_W-1:0] phase_counts[10];
    logic [NUSE_W-1:0] cnt;
    sb = new();
    phase_counts = '{4'd12, 4'd7, 4'd0, 4'd15, 4'd3, 4'd12, 4'd1, 4'd9, 4'd13, 4'd5};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, starting from the reset count of twelve.
    set_idle(IDLE_NONE);
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(479001599));
    send_rank(RANK_W'(479001600));
    send_rank(RANK_ALL_ONES);
    write_count(4'd1);
    send_rank('0);
    send_rank(RANK_ALL_ONES);
    // A count of zero behaves as a single element.
    write_count(4'd0);
    send_rank(RANK_W'(12345));
    write_count(4'd2);
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(2));
    send_rank(RANK_W'(3));
    // Counts above twelve saturate.
    write_count(4'd15);
    send_rank(RANK_W'(5));
    send_rank(RANK_W'(479001599));
    write_count(4'd13);
    send_rank(RANK_W'(479001601));

    // Random part: each phase gets its own count and idling mode.
    for (int p = 0; p < 10; p++) begin
      cnt = (p == 9) ? NUSE_W'($urandom_range(15)) : phase_counts[p];
      write_count(cnt);
      set_idle(idle_mode_t'(p % 4));
      if (p == 2 || p == 8) hold_req <= hold_req + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) send_rank(pick_rank(sb.elem_count()));
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
